@@ rtl/core/smj_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smj_pkg
// Shared types and codes for the sort-merge equi-join engine.
// ----------------------------------------------------------------------------
package smj_pkg;

    localparam int KEY_W  = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // input op codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_MATCH = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ORDER = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;    // capture the accepted beat
        logic load_write;  // append tuple to the store
        logic emit_err;    // send load error result
        logic clear;       // empty store and pointers
        logic start_probe; // rewind or drop mark, record probe key
        logic rd_issue;    // read store at scan pointer
        logic step_skip;   // stored key below probe key, advance
        logic match;       // equal keys, take pair and advance
        logic flush;       // send held pair as the final one
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            load_bad;  // full store or key out of order
        logic            in_range;  // scan pointer below stored count
        logic            key_lt;    // read key below probe key
        logic            key_eq;    // read key equals probe key
        logic            hold_valid;
        logic            out_free;  // output register can take a beat
    } t_sts;

endpackage

@@ rtl/core/smj_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smj_ctrl
// Sequencer for load, clear and probe items of the join engine.
// ----------------------------------------------------------------------------
module smj_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  smj_pkg::t_sts i_sts,
    output smj_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    smj_pkg::OP_LOAD: begin
                        if (!i_sts.load_bad) begin
                            o_cmd.load_write = 1'b1;
                            n_state          = S_IDLE;
                        end else if (i_sts.out_free) begin
                            o_cmd.emit_err = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    smj_pkg::OP_PROBE: begin
                        o_cmd.start_probe = 1'b1;
                        n_state           = S_READ;
                    end
                    smj_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                if (i_sts.in_range) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_CMP;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_CMP: begin
                if (i_sts.key_lt) begin
                    o_cmd.step_skip = 1'b1;
                    n_state         = S_READ;
                end else if (i_sts.key_eq) begin
                    if (!i_sts.hold_valid || i_sts.out_free) begin
                        o_cmd.match = 1'b1;
                        n_state     = S_READ;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/smj_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smj_datapath
// Tuple store, scan pointer and run mark, held pair and output register.
// ----------------------------------------------------------------------------
module smj_datapath #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [smj_pkg::OP_W-1:0]     i_op,
    input  logic [smj_pkg::KEY_W-1:0]    i_key,
    input  logic [smj_pkg::KEY_W-1:0]    i_val,
    input  smj_pkg::t_cmd                i_cmd,
    output smj_pkg::t_sts                o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [smj_pkg::STAT_W-1:0]   o_status,
    output logic [smj_pkg::KEY_W-1:0]    o_left_key,
    output logic [smj_pkg::KEY_W-1:0]    o_left_value,
    output logic [smj_pkg::KEY_W-1:0]    o_right_key,
    output logic [smj_pkg::KEY_W-1:0]    o_right_value,
    output logic                         o_last
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    // tuple store
    logic [smj_pkg::KEY_W-1:0] r_mem_key [STORE_DEPTH];
    logic [smj_pkg::KEY_W-1:0] r_mem_val [STORE_DEPTH];

    // accepted item
    logic [smj_pkg::OP_W-1:0]  r_op;
    logic signed [smj_pkg::KEY_W-1:0] r_key;
    logic [smj_pkg::KEY_W-1:0] r_val;

    // scan state
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_scan;
    logic [CW-1:0]             r_mark;
    logic                      r_mark_valid;
    logic [smj_pkg::KEY_W-1:0] r_prev_key;
    logic signed [smj_pkg::KEY_W-1:0] r_last_key;

    // read data and held pair
    logic signed [smj_pkg::KEY_W-1:0] r_rd_key;
    logic [smj_pkg::KEY_W-1:0] r_rd_val;
    logic                      r_hold_valid;
    logic [smj_pkg::KEY_W-1:0] r_hold_key;
    logic [smj_pkg::KEY_W-1:0] r_hold_val;

    // output register
    logic                       r_out_valid;
    logic [smj_pkg::STAT_W-1:0] r_out_status;
    logic [smj_pkg::KEY_W-1:0]  r_out_lkey;
    logic [smj_pkg::KEY_W-1:0]  r_out_lval;
    logic [smj_pkg::KEY_W-1:0]  r_out_rkey;
    logic [smj_pkg::KEY_W-1:0]  r_out_rval;
    logic                       r_out_last;

    logic full;
    logic order_bad;
    logic out_free;

    assign full      = (r_count >= DEPTH_C);
    assign order_bad = (r_count != '0) && (r_key < r_last_key);
    assign out_free  = !r_out_valid || i_out_ready;

    // status to controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.load_bad   = full || order_bad;
        o_sts.in_range   = (r_scan < r_count);
        o_sts.key_lt     = (r_rd_key < r_key);
        o_sts.key_eq     = (r_rd_key == r_key);
        o_sts.hold_valid = r_hold_valid;
        o_sts.out_free   = out_free;
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_val <= i_val;
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            r_mem_key[r_count[AW-1:0]] <= r_key;
            r_mem_val[r_count[AW-1:0]] <= r_val;
        end
        if (i_cmd.rd_issue) begin
            r_rd_key <= r_mem_key[r_scan[AW-1:0]];
            r_rd_val <= r_mem_val[r_scan[AW-1:0]];
        end
    end

    // last stored key for the order check
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            r_last_key <= r_key;
        end
    end

    // count, scan pointer, run mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_scan       <= '0;
            r_mark       <= '0;
            r_mark_valid <= 1'b0;
            r_prev_key   <= '0;
        end else if (i_cmd.clear) begin
            r_count      <= '0;
            r_scan       <= '0;
            r_mark       <= '0;
            r_mark_valid <= 1'b0;
            r_prev_key   <= '0;
        end else begin
            if (i_cmd.load_write) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.start_probe) begin
                r_prev_key <= r_key;
                if (r_mark_valid) begin
                    if (r_key == r_prev_key) begin
                        r_scan <= r_mark;
                    end else begin
                        r_mark_valid <= 1'b0;
                    end
                end
            end
            if (i_cmd.step_skip) begin
                r_scan       <= r_scan + CW'(1);
                r_mark_valid <= 1'b0;
            end
            if (i_cmd.match) begin
                r_scan <= r_scan + CW'(1);
                if (!r_mark_valid) begin
                    r_mark       <= r_scan;
                    r_mark_valid <= 1'b1;
                end
            end
        end
    end

    // held pair, sent once the next compare shows whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (i_cmd.match) begin
            r_hold_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_hold_key <= r_rd_key;
            r_hold_val <= r_rd_val;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_err || i_cmd.flush || (i_cmd.match && r_hold_valid)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_out_status <= full ? smj_pkg::STAT_FULL : smj_pkg::STAT_ORDER;
            r_out_lkey   <= r_key;
            r_out_lval   <= r_val;
            r_out_rkey   <= '0;
            r_out_rval   <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.flush || (i_cmd.match && r_hold_valid)) begin
            r_out_status <= smj_pkg::STAT_MATCH;
            r_out_lkey   <= r_key;
            r_out_lval   <= r_val;
            r_out_rkey   <= r_hold_key;
            r_out_rval   <= r_hold_val;
            r_out_last   <= i_cmd.flush;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_left_key    = r_out_lkey;
    assign o_left_value  = r_out_lval;
    assign o_right_key   = r_out_rkey;
    assign o_right_value = r_out_rval;
    assign o_last        = r_out_last;

endmodule

@@ rtl/core/sort_merge_join.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_merge_join
// Equi-join of a loaded, key-sorted S relation with a key-sorted R stream.
// ----------------------------------------------------------------------------
// channel   dir  tdata                              tuser    tlast
// s_axis    in   key, value                         op       -
// m_axis    out  left key/value, right key/value    status   final pair
//
// load, clear and undefined ops are decoded and return to idle; a load error
// also waits for a free output register. a probe reads each stored tuple it
// visits through the single store read port, then compares its key, and ends
// once a stored key passes the probe key or the scan runs past the last tuple.
// the output register lets a new item be accepted while a beat waits.
// a stalled m_axis holds the engine at the next result it must send.
// i_rst_n (synchronous) empties the store and clears pointers and the mark.
// ----------------------------------------------------------------------------
module sort_merge_join #(
    parameter int STORE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // tuple_key, tuple_value
    input  logic [1:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // left_key, left_value, right_key, right_value
    output logic [1:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast
);

    smj_pkg::t_cmd cmd;
    smj_pkg::t_sts sts;

    smj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smj_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (s_axis_tuser),
        .i_key         (s_axis_tdata[31:0]),
        .i_val         (s_axis_tdata[63:32]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_left_key    (m_axis_tdata[31:0]),
        .o_left_value  (m_axis_tdata[63:32]),
        .o_right_key   (m_axis_tdata[95:64]),
        .o_right_value (m_axis_tdata[127:96]),
        .o_last        (m_axis_tlast)
    );

endmodule
